// ===== hdl/voalloc_pkg.sv =====
`default_nettype none

package voalloc_pkg;

	localparam int NUM_VOICES_DEF = 16;

	localparam int KIND_W  = 3;
	localparam int NOTE_W  = 7;
	localparam int CHAN_W  = 4;
	localparam int VEL_W   = 16;
	localparam int FIN_W   = 4;
	localparam int SLOT_W  = 4;
	localparam int MASK_W  = 16;
	localparam int ORDER_W = 32;

	// event codes; all notes off is controller 123 upstream
	typedef enum logic [KIND_W-1:0] {
		KIND_NOTE_ON  = 3'd0,
		KIND_NOTE_OFF = 3'd1,
		KIND_ALL_OFF  = 3'd2,
		KIND_FINISHED = 3'd3,
		KIND_CLEAR    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NOTE_W-1:0] note_number;
		logic [CHAN_W-1:0] midi_channel;
		logic [VEL_W-1:0]  velocity_in;
		logic [FIN_W-1:0]  finished_voice;
	} in_word_t;

	typedef struct packed {
		logic              slot_valid;
		logic [SLOT_W-1:0] assigned_slot;
		logic              was_stolen;
		logic [MASK_W-1:0] release_mask;
		logic [VEL_W-1:0]  velocity_out;
	} out_word_t;

	typedef struct packed {
		logic [NOTE_W-1:0]  note;
		logic [CHAN_W-1:0]  chan;
		logic [ORDER_W-1:0] order;
	} voice_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/voalloc_in_if.sv =====
`default_nettype none

interface voalloc_in_if;
	logic                  valid;
	logic                  ready;
	voalloc_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/voalloc_out_if.sv =====
`default_nettype none

interface voalloc_out_if;
	logic                   valid;
	logic                   ready;
	voalloc_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/voalloc_ctrl.sv =====
`default_nettype none

module voalloc_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  voalloc_pkg::dp_status_t status,
	output voalloc_pkg::ctl_cmd_t   cmd
);

	voalloc_pkg::state_t state_q;
	voalloc_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= voalloc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			voalloc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start  = 1'b1;
					state_next = voalloc_pkg::ST_SCAN;
				end
			end
			voalloc_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_next = voalloc_pkg::ST_TAIL;
				end
			end
			// last table entry is evaluated here
			voalloc_pkg::ST_TAIL: begin
				state_next = voalloc_pkg::ST_FINISH;
			end
			voalloc_pkg::ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_next = voalloc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = voalloc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/voalloc_dp.sv =====
`default_nettype none

module voalloc_dp #(
	parameter int NUM_VOICES = voalloc_pkg::NUM_VOICES_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  voalloc_pkg::ctl_cmd_t   cmd,
	output voalloc_pkg::dp_status_t status,
	input  voalloc_pkg::in_word_t   in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output voalloc_pkg::out_word_t  out_data
);

	localparam int VIDX_W = $clog2(NUM_VOICES);
	localparam int PAD_W  = (NUM_VOICES > voalloc_pkg::MASK_W) ? NUM_VOICES
	                                                           : voalloc_pkg::MASK_W;

	voalloc_pkg::in_word_t     op_q;
	logic [NUM_VOICES-1:0]     act_q;
	logic [voalloc_pkg::ORDER_W-1:0] order_q;

	voalloc_pkg::voice_entry_t mem [NUM_VOICES];
	voalloc_pkg::voice_entry_t rd_data_s1;
	logic                      rd_en_s1;
	logic [VIDX_W-1:0]         rd_idx_s1;
	logic [VIDX_W-1:0]         scan_idx_q;

	logic                      free_found_q;
	logic [VIDX_W-1:0]         free_idx_q;
	logic                      best_found_q;
	logic [VIDX_W-1:0]         best_idx_q;
	logic [voalloc_pkg::ORDER_W-1:0] best_order_q;
	logic [voalloc_pkg::MASK_W-1:0]  mask_q;

	voalloc_pkg::out_word_t    out_q;
	logic                      out_valid_q;

	logic                      rd_act;
	logic                      hit_free;
	logic                      hit_old;
	logic                      hit_match;
	logic [VIDX_W-1:0]         slot;
	logic                      fin_ok;
	logic [VIDX_W-1:0]         fin_idx;
	logic [PAD_W-1:0]          act_pad;
	logic                      note_on_commit;
	voalloc_pkg::out_word_t    out_next;
	voalloc_pkg::voice_entry_t wr_entry;

	assign status.scan_last = (scan_idx_q == VIDX_W'(NUM_VOICES - 1));
	assign status.out_busy  = out_valid_q;
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_en_s1   <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			if (cmd.start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			rd_en_s1  <= cmd.scan;
			rd_idx_s1 <= scan_idx_q;
		end
	end

	// voice table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (note_on_commit) begin
			mem[slot] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_data_s1 <= mem[scan_idx_q];
		end
	end

	// per-entry evaluation of the walked voice
	always_comb begin
		rd_act    = act_q[rd_idx_s1];
		hit_free  = rd_en_s1 && !rd_act && !free_found_q;
		hit_old   = rd_en_s1 && rd_act
		            && (!best_found_q || (rd_data_s1.order < best_order_q));
		hit_match = rd_en_s1 && rd_act
		            && (rd_data_s1.note == op_q.note_number)
		            && (rd_data_s1.chan == op_q.midi_channel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_order_q <= '0;
			mask_q       <= '0;
		end else if (cmd.start) begin
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			mask_q       <= '0;
		end else begin
			if (hit_free) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
			// strict compare keeps the lowest index on ties
			if (hit_old) begin
				best_found_q <= 1'b1;
				best_idx_q   <= rd_idx_s1;
				best_order_q <= rd_data_s1.order;
			end
			// voices past the mask width shift out
			if (hit_match) begin
				mask_q <= mask_q | (voalloc_pkg::MASK_W'(1) << rd_idx_s1);
			end
		end
	end

	always_comb begin
		slot           = free_found_q ? free_idx_q : best_idx_q;
		fin_ok         = int'(op_q.finished_voice) < NUM_VOICES;
		fin_idx        = VIDX_W'(op_q.finished_voice);
		act_pad        = PAD_W'(act_q);
		note_on_commit = cmd.commit && (op_q.kind == voalloc_pkg::KIND_NOTE_ON);
		wr_entry.note  = op_q.note_number;
		wr_entry.chan  = op_q.midi_channel;
		wr_entry.order = order_q;
		out_next       = '0;
		case (op_q.kind)
			voalloc_pkg::KIND_NOTE_ON: begin
				out_next.slot_valid    = 1'b1;
				out_next.assigned_slot = voalloc_pkg::SLOT_W'(slot);
				out_next.was_stolen    = !free_found_q;
				out_next.velocity_out  = op_q.velocity_in;
			end
			voalloc_pkg::KIND_NOTE_OFF: begin
				out_next.release_mask = mask_q;
			end
			voalloc_pkg::KIND_ALL_OFF: begin
				out_next.release_mask = act_pad[voalloc_pkg::MASK_W-1:0];
			end
			default: begin
				out_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			order_q <= '0;
		end else if (cmd.commit) begin
			case (op_q.kind)
				voalloc_pkg::KIND_NOTE_ON: begin
					act_q[slot] <= 1'b1;
					order_q     <= order_q + 1'b1;
				end
				voalloc_pkg::KIND_FINISHED: begin
					if (fin_ok) begin
						act_q[fin_idx] <= 1'b0;
					end
				end
				voalloc_pkg::KIND_CLEAR: begin
					act_q   <= '0;
					order_q <= '0;
				end
				default: begin
					order_q <= order_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q)
		else $error("result committed over an untaken word");

	a_word_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result word appeared without a commit");

	a_order_step: assert property (@(posedge clk) disable iff (!arst_n)
		note_on_commit |=> order_q == $past(order_q) + 1'b1)
		else $error("order counter did not advance on note on");

	a_slot_active: assert property (@(posedge clk) disable iff (!arst_n)
		note_on_commit |=> act_q[$past(slot)])
		else $error("assigned voice not active after note on");

	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !cmd.commit && !cmd.start)
		else $error("table walk overlaps start or commit");

endmodule

`default_nettype wire

// ===== hdl/voice_allocator_oldest_steal_core.sv =====
`default_nettype none

// channel  dir  payload     word
// evt      in   in_word_t   kind, note, channel, velocity, finished voice
// res      out  out_word_t  slot, steal flag, release mask, velocity
//
// events are handled one at a time: the walk reads
// the voice table through its single read port, one voice a cycle
// evt is ready only while idle; the result sits in an output register
// a held result stalls the commit step until res takes it
// reset clears active bits, order counter and control; table needs no clear

module voice_allocator_oldest_steal_core #(
	parameter int NUM_VOICES = voalloc_pkg::NUM_VOICES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	voalloc_in_if.sink   evt,
	voalloc_out_if.source res
);

	voalloc_pkg::ctl_cmd_t   cmd;
	voalloc_pkg::dp_status_t status;
	logic                    ready;
	logic                    valid;
	voalloc_pkg::out_word_t  data;

	assign evt.ready = ready;
	assign res.valid = valid;
	assign res.data  = data;

	voalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	voalloc_dp #(
		.NUM_VOICES (NUM_VOICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (evt.data),
		.out_valid (valid),
		.out_ready (res.ready),
		.out_data  (data)
	);

endmodule

`default_nettype wire

// ===== tb/voalloc_checker.sv =====
`timescale 1ns / 100ps

module voalloc_checker
	import voalloc_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	voalloc_in_if  evt,
	voalloc_out_if res,
	output int     fail_count,
	output int     due_count
);

	localparam int NV = NUM_VOICES_DEF;

	// shadow voice table, entries never written read as zero
	logic               voice_on   [NV] = '{default: '0};
	logic [NOTE_W-1:0]  voice_key  [NV] = '{default: '0};
	logic [CHAN_W-1:0]  voice_chan [NV] = '{default: '0};
	logic [ORDER_W-1:0] voice_age  [NV] = '{default: '0};
	logic [ORDER_W-1:0] age_counter = '0;

	out_word_t slot_results_due [$];
	int        mismatches = 0;
	int        waiting = 0;

	assign fail_count = mismatches;
	assign due_count  = waiting;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  res word: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic out_word_t voice_table_step(input in_word_t w);
		out_word_t r;
		int        slot;
		bit        found;
		r = '0;
		case (w.kind)
			KIND_NOTE_ON: begin
				found = 1'b0;
				slot  = 0;
				for (int i = 0; i < NV; i++)
					if (!found && !voice_on[i]) begin
						found = 1'b1;
						slot  = i;
					end
				// table full: oldest start order loses, ties to the lower voice
				if (!found)
					for (int i = 1; i < NV; i++)
						if (voice_age[i] < voice_age[slot])
							slot = i;
				voice_on[slot]   = 1'b1;
				voice_key[slot]  = w.note_number;
				voice_chan[slot] = w.midi_channel;
				voice_age[slot]  = age_counter;
				age_counter      = age_counter + 1'b1;
				r.slot_valid     = 1'b1;
				r.assigned_slot  = slot[SLOT_W-1:0];
				r.was_stolen     = !found;
				r.velocity_out   = w.velocity_in;
			end
			KIND_NOTE_OFF: begin
				for (int i = 0; i < NV && i < MASK_W; i++)
					if (voice_on[i] && voice_key[i] == w.note_number
							&& voice_chan[i] == w.midi_channel)
						r.release_mask[i] = 1'b1;
			end
			KIND_ALL_OFF: begin
				for (int i = 0; i < NV && i < MASK_W; i++)
					if (voice_on[i])
						r.release_mask[i] = 1'b1;
			end
			KIND_FINISHED: begin
				if (w.finished_voice < NV)
					voice_on[w.finished_voice] = 1'b0;
			end
			KIND_CLEAR: begin
				for (int i = 0; i < NV; i++)
					voice_on[i] = 1'b0;
				age_counter = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NV; i++)
				voice_on[i] = 1'b0;
			age_counter = '0;
			slot_results_due.delete();
			waiting <= 0;
		end else begin
			// result side first, so a stray word is never matched to this edge's event
			if (res.valid && res.ready) begin
				if (slot_results_due.size() == 0) begin
					report_mismatch($sformatf("no event waiting, got %h", res.data));
				end else begin
					want = slot_results_due.pop_front();
					if (res.data.slot_valid !== want.slot_valid)
						report_mismatch($sformatf("slot_valid %b, want %b",
							res.data.slot_valid, want.slot_valid));
					if (res.data.assigned_slot !== want.assigned_slot)
						report_mismatch($sformatf("assigned_slot %0d, want %0d",
							res.data.assigned_slot, want.assigned_slot));
					if (res.data.was_stolen !== want.was_stolen)
						report_mismatch($sformatf("was_stolen %b, want %b",
							res.data.was_stolen, want.was_stolen));
					if (res.data.release_mask !== want.release_mask)
						report_mismatch($sformatf("release_mask %h, want %h",
							res.data.release_mask, want.release_mask));
					if (res.data.velocity_out !== want.velocity_out)
						report_mismatch($sformatf("velocity_out %h, want %h",
							res.data.velocity_out, want.velocity_out));
				end
			end
			if (evt.valid && evt.ready)
				slot_results_due.push_back(voice_table_step(evt.data));
			waiting <= slot_results_due.size();
		end
	end

endmodule

// ===== tb/tb_voice_allocator_oldest_steal_core.sv =====
`timescale 1ns / 100ps

module tb_voice_allocator_oldest_steal_core;
	import voalloc_pkg::*;

	localparam int RANDOM_EVENTS = 1300;
	localparam int CALM_FIRST    = 700;
	localparam int CALM_LAST     = 950;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   fail_count;
	int   due_count;

	in_word_t                  event_words [$];
	logic [NOTE_W+CHAN_W-1:0]  played [$];

	voalloc_in_if  evt_ch ();
	voalloc_out_if res_ch ();

	voice_allocator_oldest_steal_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	voalloc_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_voice_allocator_oldest_steal_core: errors");
			$finish;
		end
	end

	// result side stalls about a quarter of the time, never in the calm stretch
	always @(posedge clk)
		if (arst_n)
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 25);

	function automatic in_word_t ev(input logic [KIND_W-1:0] kind, input int note,
			input int chan, input int vel, input int fin);
		in_word_t w;
		w.kind           = kind;
		w.note_number    = note[NOTE_W-1:0];
		w.midi_channel   = chan[CHAN_W-1:0];
		w.velocity_in    = vel[VEL_W-1:0];
		w.finished_voice = fin[FIN_W-1:0];
		return w;
	endfunction

	function automatic in_word_t noise_word();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(in_word_t)-1:0];
	endfunction

	task automatic build_events();
		in_word_t w;
		int       pick;
		// empty table, then fill it with one note held by fourteen voices
		event_words.push_back(ev(KIND_NOTE_OFF, 0, 0, 0, 0));
		for (int v = 0; v < NUM_VOICES_DEF; v++)
			event_words.push_back(ev(KIND_NOTE_ON,
				v == 0 ? 0 : (v == NUM_VOICES_DEF - 1 ? 127 : 64),
				v == 0 ? 0 : (v == NUM_VOICES_DEF - 1 ? 15 : 9),
				v == 0 ? 0 : (v == NUM_VOICES_DEF - 1 ? 'hffff : $urandom_range(1, 'hfffe)),
				0));
		event_words.push_back(ev(KIND_NOTE_ON, 1, 1, 'h8000, 0));
		event_words.push_back(ev(KIND_NOTE_OFF, 64, 9, 'hffff, 15));
		event_words.push_back(ev(KIND_NOTE_OFF, 64, 8, 0, 0));
		event_words.push_back(ev(KIND_ALL_OFF, 127, 15, 'hffff, 15));
		event_words.push_back(ev(KIND_FINISHED, 0, 0, 0, 15));
		event_words.push_back(ev(KIND_FINISHED, 127, 15, 'hffff, 0));
		// refill the freed voices lowest first, then steal again
		event_words.push_back(ev(KIND_NOTE_ON, 5, 3, 'h1234, 0));
		event_words.push_back(ev(KIND_NOTE_ON, 6, 3, 'h5678, 0));
		event_words.push_back(ev(KIND_NOTE_ON, 7, 3, 'h9abc, 0));
		event_words.push_back(ev(KIND_W'((1 << KIND_W) - 1), 127, 15, 'hffff, 15));
		event_words.push_back(ev(KIND_CLEAR, 0, 0, 0, 0));

		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			w    = noise_word();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				w.kind = KIND_NOTE_ON;
				if ($urandom_range(0, 3) != 0) begin
					w.note_number  = NOTE_W'(48 + $urandom_range(0, 11));
					w.midi_channel = CHAN_W'($urandom_range(0, 3));
				end
				played.push_back({w.note_number, w.midi_channel});
				if (played.size() > 24)
					void'(played.pop_front());
			end else if (pick < 72) begin
				w.kind = KIND_NOTE_OFF;
				if (played.size() > 0 && $urandom_range(0, 9) < 8)
					{w.note_number, w.midi_channel} = played[$urandom_range(0, played.size() - 1)];
			end else if (pick < 87) begin
				w.kind = KIND_FINISHED;
			end else if (pick < 93) begin
				w.kind = KIND_ALL_OFF;
			end else if (pick < 96) begin
				w.kind = KIND_CLEAR;
			end else begin
				w.kind = KIND_W'($urandom_range(KIND_CLEAR + 1, (1 << KIND_W) - 1));
			end
			event_words.push_back(w);
		end
	endtask

	task automatic drive_events();
		int i;
		i = 0;
		while (i < event_words.size()) begin
			calm = (i >= CALM_FIRST && i < CALM_LAST);
			if (!calm && $urandom_range(0, 99) < 25) begin
				evt_ch.valid <= 1'b0;
				@(posedge clk);
			end else begin
				evt_ch.valid <= 1'b1;
				evt_ch.data  <= event_words[i];
				@(posedge clk);
				while (!evt_ch.ready)
					@(posedge clk);
				i++;
			end
		end
		evt_ch.valid <= 1'b0;
		calm = 1'b0;
	endtask

	initial begin
		evt_ch.valid = 1'b0;
		evt_ch.data  = '0;
		res_ch.ready = 1'b0;
		build_events();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_events();
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("tb_voice_allocator_oldest_steal_core: clean");
		else
			$display("tb_voice_allocator_oldest_steal_core: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/voalloc_pkg.sv
hdl/voalloc_in_if.sv
hdl/voalloc_out_if.sv
hdl/voalloc_ctrl.sv
hdl/voalloc_dp.sv
hdl/voice_allocator_oldest_steal_core.sv
tb/voalloc_checker.sv
tb/tb_voice_allocator_oldest_steal_core.sv
